// File: src/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

  // Field widths of one term
  localparam int unsigned EXP_W  = 16;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned OP_W   = 2;

  // Default list depth
  localparam int unsigned MAX_TERMS_DEF = 16;

  // Command queue between front and back, a power of two
  localparam int unsigned Q_DEPTH = 2;

  // Operation codes on the input channel
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Saturation limits of a Q16.16 coefficient
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    logic [EXP_W-1:0]         exp;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  typedef struct packed {
    cmd_kind_t kind;
    term_t     term;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_MERGE
  } bk_state_t;

endpackage

`default_nettype wire

// File: src/spa_front.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [47:0]               in_tdata,
  input  wire logic [spa_pkg::OP_W-1:0]  in_tuser,
  output logic                           cmd_valid,
  output spa_pkg::cmd_t                  cmd,
  input  wire logic                      cmd_pop
);

  localparam int unsigned PTR_W = (spa_pkg::Q_DEPTH > 1) ? $clog2(spa_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(spa_pkg::Q_DEPTH + 1);

  spa_pkg::cmd_t    q_r [spa_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  spa_pkg::cmd_t    in_cmd;
  logic             op_known;
  logic             push;
  logic             pop;

  // Classify the operation; reserved codes are taken and dropped
  always_comb begin
    in_cmd.term.exp  = in_tdata[15:0];
    in_cmd.term.coef = in_tdata[47:16];
    in_cmd.kind      = spa_pkg::CMD_LOAD_A;
    op_known         = 1'b1;
    case (in_tuser)
      spa_pkg::OP_LOAD_A:  in_cmd.kind = spa_pkg::CMD_LOAD_A;
      spa_pkg::OP_LOAD_B:  in_cmd.kind = spa_pkg::CMD_LOAD_B;
      spa_pkg::OP_COMPUTE: in_cmd.kind = spa_pkg::CMD_COMPUTE;
      default:             op_known    = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != CNT_W'(spa_pkg::Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  assign push = in_tvalid && in_tready && op_known;
  assign pop  = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/spa_back.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_back #(
  parameter int unsigned MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  input  wire spa_pkg::cmd_t                  cmd,
  output logic                                cmd_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [spa_pkg::EXP_W-1:0]           out_exp,
  output logic signed [spa_pkg::COEF_W-1:0]   out_coef,
  output logic                                out_tlast,
  output logic                                out_empty
);

  localparam int unsigned IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned COEF_W = spa_pkg::COEF_W;

  spa_pkg::term_t       terms_a_r [MAX_TERMS];
  spa_pkg::term_t       terms_b_r [MAX_TERMS];

  spa_pkg::bk_state_t   state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]     cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]     ia_r, ia_nxt;
  logic [CNT_W-1:0]     ib_r, ib_nxt;

  logic                 pend_valid_r, pend_valid_nxt;
  spa_pkg::term_t       pend_r, pend_nxt;

  logic                 out_valid_r, out_valid_nxt;
  spa_pkg::term_t       out_term_r, out_term_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_empty_r, out_empty_nxt;

  // Merge datapath
  spa_pkg::term_t       ta, tb;
  logic                 a_ok, b_ok, walk_done;
  logic                 match, take_a;
  logic [COEF_W:0]      sum_w;
  logic signed [COEF_W-1:0] sum_sat;
  logic                 prod_valid;
  spa_pkg::term_t       prod;
  logic                 adv_a, adv_b;
  logic                 out_free;

  // Control
  logic                 wr_a, wr_b, start, adv, fin, push_pend;

  assign ta        = terms_a_r[ia_r[IDX_W-1:0]];
  assign tb        = terms_b_r[ib_r[IDX_W-1:0]];
  assign a_ok      = (ia_r < cnt_a_r);
  assign b_ok      = (ib_r < cnt_b_r);
  assign walk_done = !a_ok && !b_ok;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    sum_w = {ta.coef[COEF_W-1], ta.coef} + {tb.coef[COEF_W-1], tb.coef};
    if (sum_w[COEF_W] != sum_w[COEF_W-1]) begin
      sum_sat = sum_w[COEF_W] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
    end else begin
      sum_sat = sum_w[COEF_W-1:0];
    end
  end

  // One merge step: equal exponents add, otherwise the larger exponent passes
  always_comb begin
    match      = a_ok && b_ok && (ta.exp == tb.exp);
    take_a     = !match && (!b_ok || (a_ok && (ta.exp > tb.exp)));
    prod_valid = 1'b1;
    prod       = tb;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    if (match) begin
      prod.exp   = ta.exp;
      prod.coef  = sum_sat;
      prod_valid = (sum_sat != '0);
      adv_a      = 1'b1;
      adv_b      = 1'b1;
    end else if (take_a) begin
      prod  = ta;
      adv_a = 1'b1;
    end else begin
      adv_b = 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spa_pkg::BK_IDLE: begin
        if (cmd_valid && (cmd.kind == spa_pkg::CMD_COMPUTE)) begin
          state_nxt = spa_pkg::BK_MERGE;
        end
      end
      spa_pkg::BK_MERGE: begin
        if (walk_done && out_free) begin
          state_nxt = spa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = spa_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    cmd_pop = 1'b0;
    wr_a    = 1'b0;
    wr_b    = 1'b0;
    start   = 1'b0;
    adv     = 1'b0;
    fin     = 1'b0;
    case (state_r)
      spa_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            spa_pkg::CMD_LOAD_A:  wr_a  = (cnt_a_r < CNT_W'(MAX_TERMS));
            spa_pkg::CMD_LOAD_B:  wr_b  = (cnt_b_r < CNT_W'(MAX_TERMS));
            spa_pkg::CMD_COMPUTE: start = 1'b1;
            default:              start = 1'b0;
          endcase
        end
      end
      spa_pkg::BK_MERGE: begin
        if (walk_done) begin
          fin = out_free;
        end else begin
          // hold the step while a new term and the held term both wait and the output is stalled
          adv = !(prod_valid && pend_valid_r && !out_free);
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign push_pend = adv && prod_valid && pend_valid_r;

  always_comb begin
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_term_nxt   = out_term_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;

    if (wr_a) cnt_a_nxt = cnt_a_r + CNT_W'(1);
    if (wr_b) cnt_b_nxt = cnt_b_r + CNT_W'(1);

    if (start) begin
      ia_nxt         = '0;
      ib_nxt         = '0;
      pend_valid_nxt = 1'b0;
    end

    if (out_tready) out_valid_nxt = 1'b0;

    if (adv) begin
      ia_nxt = ia_r + CNT_W'(adv_a);
      ib_nxt = ib_r + CNT_W'(adv_b);
      if (prod_valid) begin
        pend_valid_nxt = 1'b1;
        pend_nxt       = prod;
      end
    end

    if (push_pend) begin
      out_valid_nxt = 1'b1;
      out_term_nxt  = pend_r;
      out_last_nxt  = 1'b0;
      out_empty_nxt = 1'b0;
    end

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      out_empty_nxt  = !pend_valid_r;
      out_term_nxt   = pend_valid_r ? pend_r : '0;
      pend_valid_nxt = 1'b0;
      cnt_a_nxt      = '0;
      cnt_b_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spa_pkg::BK_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r      <= pend_nxt;
    out_term_r  <= out_term_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    if (wr_a) terms_a_r[cnt_a_r[IDX_W-1:0]] <= cmd.term;
    if (wr_b) terms_b_r[cnt_b_r[IDX_W-1:0]] <= cmd.term;
  end

  assign out_tvalid = out_valid_r;
  assign out_exp    = out_term_r.exp;
  assign out_coef   = out_term_r.coef;
  assign out_tlast  = out_last_r;
  assign out_empty  = out_empty_r;

endmodule

`default_nettype wire

// File: src/sparse_polynomial_adder_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sparse polynomial adder.
// Input channel (in_*): one transaction per command. in_tuser selects the
// command: load a term into list A, load a term into list B, or compute.
// Reserved codes are accepted and dropped. Loads into a full list are lost.
// Output channel (out_*): one transaction per term of A + B, the larger exponent
// first at each merge step, out_tlast on the final one. A sum with no terms
// gives one transaction with out_tuser set, out_tlast set and zero data. Both
// lists clear afterward. The back end retires one load per cycle while idle;
// during a compute the merge walk advances one step per cycle unless the
// output stalls it, reading each list's register file once per step; one term
// is held back in a register so the last flag is known. A load reaches its
// list through the command queue.
// A stalled receiver holds the output register and then the merge walk; the
// command queue keeps taking transactions until it fills.
// Reset (rst_n low, synchronous) empties the queue and both lists and drops
// any result not yet taken; list contents themselves are not cleared.
module sparse_polynomial_adder_unit #(
  parameter int unsigned MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] exponent, [47:16] coefficient
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] exponent_res, [47:16] coefficient_res
  output logic             out_tlast,
  output logic [0:0]       out_tuser   // [0] empty_res
);

  logic                                    cmd_valid;
  spa_pkg::cmd_t                           cmd;
  logic                                    cmd_pop;
  logic [spa_pkg::EXP_W-1:0]               res_exp;
  logic signed [spa_pkg::COEF_W-1:0]       res_coef;
  logic                                    res_empty;

  // Accept and classify commands, queue them for the back end
  spa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Hold the term lists, run the merge walk, drive the result register
  spa_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_exp    (res_exp),
    .out_coef   (res_coef),
    .out_tlast  (out_tlast),
    .out_empty  (res_empty)
  );

  assign out_tdata = {res_coef, res_exp};
  assign out_tuser = res_empty;

endmodule

`default_nettype wire

// File: src/spa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module spa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An empty sum is a single, final, all-zero transaction
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == 48'd0))
    else $error("empty result not final or not zero");

  // Reset drops any pending result
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the command queue
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind sparse_polynomial_adder_unit spa_checker u_spa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: verif/sparse_polynomial_adder_unit_tb.sv
`timescale 1ns / 1ps

module sparse_polynomial_adder_unit_tb;

  localparam int unsigned MAX_TERMS   = spa_pkg::MAX_TERMS_DEF;
  localparam logic [1:0]  OP_RESERVED = 2'd3;
  // Receiver hold-off used to back the block up into its command queue
  localparam int unsigned HOLD_CYCLES = 400;
  // Cycles to keep watching the result channel once nothing is expected
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned WATCHDOG_NS = 2_000_000;

  // One command on the input channel
  typedef struct {
    logic [1:0]         op;
    logic [15:0]        exp;
    logic signed [31:0] coef;
  } cmd_item_t;

  // One term of the expected sum
  typedef struct {
    logic [15:0]        exp;
    logic signed [31:0] coef;
    logic               last;
    logic               empty;
  } sum_term_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [15:0] exponent, [47:16] coefficient
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [15:0] exponent_res, [47:16] coefficient_res
  logic        out_tlast;
  logic [0:0]  out_tuser;       // [0] empty_res

  // Commands waiting to be offered, and the one on the bus right now
  cmd_item_t cmd_q[$];
  cmd_item_t cur_cmd;
  int unsigned items_queued = 0;

  // Shadow copy of both term lists
  spa_pkg::term_t list_a[MAX_TERMS];
  spa_pkg::term_t list_b[MAX_TERMS];
  int unsigned cnt_a = 0;
  int unsigned cnt_b = 0;

  // Sum terms still owed by the block, oldest first
  sum_term_t sum_terms_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;

  sparse_polynomial_adder_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Expected-sum calculation
  // ---------------------------------------------------------------------------

  function automatic void owe_term(logic [15:0] e, logic signed [31:0] c);
    sum_terms_q.push_back('{exp: e, coef: c, last: 1'b0, empty: 1'b0});
  endfunction

  // Add with clamping to the Q16.16 range
  function automatic logic signed [31:0] clamp_add(logic signed [31:0] x,
                                                   logic signed [31:0] y);
    logic [32:0] wide;
    wide = {x[31], x} + {y[31], y};
    if (wide[32] != wide[31]) return wide[32] ? spa_pkg::COEF_MIN : spa_pkg::COEF_MAX;
    return wide[31:0];
  endfunction

  // Apply one accepted command to the shadow lists; on compute, walk both
  // lists the way the block does and queue every term it must emit.
  function automatic void poly_add_step(cmd_item_t c);
    int unsigned        ia;
    int unsigned        ib;
    int unsigned        n;
    logic signed [31:0] s;
    ia = 0;
    ib = 0;
    n  = 0;
    case (c.op)
      spa_pkg::OP_LOAD_A: begin
        // A full list drops the term
        if (cnt_a < MAX_TERMS) begin
          list_a[cnt_a] = '{exp: c.exp, coef: c.coef};
          cnt_a++;
        end
      end
      spa_pkg::OP_LOAD_B: begin
        if (cnt_b < MAX_TERMS) begin
          list_b[cnt_b] = '{exp: c.exp, coef: c.coef};
          cnt_b++;
        end
      end
      spa_pkg::OP_COMPUTE: begin
        while (ia < cnt_a || ib < cnt_b) begin
          if (ia < cnt_a && ib < cnt_b && list_a[ia].exp == list_b[ib].exp) begin
            // Matching exponents: add, drop the term if it cancels
            s = clamp_add(list_a[ia].coef, list_b[ib].coef);
            if (s != 0) begin
              owe_term(list_a[ia].exp, s);
              n++;
            end
            ia++;
            ib++;
          end else if (ib >= cnt_b || (ia < cnt_a && list_a[ia].exp > list_b[ib].exp)) begin
            owe_term(list_a[ia].exp, list_a[ia].coef);
            n++;
            ia++;
          end else begin
            owe_term(list_b[ib].exp, list_b[ib].coef);
            n++;
            ib++;
          end
        end
        // Nothing left: one zero term flagged empty
        if (n == 0) sum_terms_q.push_back('{exp: '0, coef: '0, last: 1'b1, empty: 1'b1});
        else sum_terms_q[$].last = 1'b1;
        cnt_a = 0;
        cnt_b = 0;
      end
      default: ;  // reserved code: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued commands, predict on every accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) poly_add_step(cur_cmd);
    // Advance only when the bus is free or the current transaction just went
    if (!in_tvalid || in_tready) begin
      if (rst_n && cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_cmd.coef, cur_cmd.exp};
        in_tuser  <= cur_cmd.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_go) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transaction with the oldest owed term
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    sum_term_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sum_terms_q.size() == 0) begin
        $error("unexpected result: exponent_res %0d coefficient_res %0d last %0b empty_res %0b",
               out_tdata[15:0], $signed(out_tdata[47:16]), out_tlast, out_tuser[0]);
        errors++;
      end else begin
        want = sum_terms_q.pop_front();
        if (out_tdata[15:0] !== want.exp) begin
          $error("exponent_res: expected %0d, got %0d", want.exp, out_tdata[15:0]);
          errors++;
        end
        if ($signed(out_tdata[47:16]) !== want.coef) begin
          $error("coefficient_res: expected %0d, got %0d", want.coef,
                 $signed(out_tdata[47:16]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          errors++;
        end
        if (out_tuser[0] !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, out_tuser[0]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_cmd(logic [1:0] op, logic [15:0] e, logic signed [31:0] c);
    cmd_q.push_back('{op: op, exp: e, coef: c});
    items_queued++;
  endtask

  // Mix of extremes, zero, small values and full-range noise
  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(7))
      0:       return spa_pkg::COEF_MAX;
      1:       return spa_pkg::COEF_MIN;
      2:       return '0;
      3, 4:    return $urandom_range(131072) - 65536;
      default: return $urandom();
    endcase
  endfunction

  // Coefficient for a B term sharing its exponent with an A term: cancel,
  // double (pushes toward saturation), or unrelated
  function automatic logic signed [31:0] partner_coef(logic signed [31:0] a);
    case ($urandom_range(3))
      0:       return -a;
      1:       return a;
      default: return rand_coef();
    endcase
  endfunction

  // Build two descending term lists that share some exponents, load them
  // interleaved, then compute. Caps above MAX_TERMS overfill the lists.
  task automatic queue_sorted_pair(int unsigned cap_a, int unsigned cap_b, int unsigned gap);
    cmd_item_t          la[$];
    cmd_item_t          lb[$];
    int                 e;
    int unsigned        pick;
    logic signed [31:0] ca;
    e = ($urandom_range(3) == 0) ? 65535 : $urandom_range(65535);
    while ((la.size() < cap_a || lb.size() < cap_b) && e >= 0) begin
      pick = $urandom_range(2);  // A only, B only, or both
      if (la.size() >= cap_a) pick = 1;
      if (lb.size() >= cap_b) pick = 0;
      ca = rand_coef();
      if (pick != 1) la.push_back('{op: spa_pkg::OP_LOAD_A, exp: e[15:0], coef: ca});
      if (pick != 0)
        lb.push_back('{op: spa_pkg::OP_LOAD_B, exp: e[15:0],
                       coef: (pick == 2) ? partner_coef(ca) : rand_coef()});
      e -= $urandom_range(gap, 1);
    end
    while (la.size() != 0 || lb.size() != 0) begin
      if (lb.size() == 0 || (la.size() != 0 && $urandom_range(1) == 1)) begin
        cmd_q.push_back(la.pop_front());
      end else begin
        cmd_q.push_back(lb.pop_front());
      end
      items_queued++;
    end
    // Data on a compute is ignored; keep it random
    queue_cmd(spa_pkg::OP_COMPUTE, 16'($urandom()), $urandom());
  endtask

  // Mostly well-formed list pairs; some overfilled pairs; some raw noise
  // (any op including the reserved one, unsorted terms)
  task automatic queue_random(int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned k;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      r = $urandom_range(9);
      if (r == 0) begin
        queue_sorted_pair($urandom_range(20, MAX_TERMS), $urandom_range(20, MAX_TERMS), 2);
      end else if (r < 8) begin
        queue_sorted_pair($urandom_range(6), $urandom_range(6), $urandom_range(4, 1));
      end else begin
        k = $urandom_range(8, 1);
        repeat (k) queue_cmd(2'($urandom_range(3)), 16'($urandom()), rand_coef());
        if ($urandom_range(1) == 1)
          queue_cmd(spa_pkg::OP_COMPUTE, 16'($urandom()), $urandom());
      end
    end
  endtask

  // Hold until every command is accepted and every owed term has arrived
  task automatic wait_drained();
    while (cmd_q.size() != 0 || in_tvalid || sum_terms_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase: no idling; directed cases first
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // compute on two empty lists
    queue_cmd(spa_pkg::OP_COMPUTE, 16'h0000, 32'sd0);
    // widest exponents and coefficients, saturating high and low
    queue_cmd(spa_pkg::OP_LOAD_A, 16'hFFFF, spa_pkg::COEF_MAX);
    queue_cmd(spa_pkg::OP_LOAD_A, 16'h0000, spa_pkg::COEF_MIN);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'hFFFF, 32'sd1);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'h0000, -32'sd1);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'hFFFF, 32'hFFFF_FFFF);
    // exact cancellation leaves an empty sum
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd100, 32'sh1234_5678);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'd100, -32'sh1234_5678);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'd0, 32'sd0);
    // zero coefficient on an unmatched term passes through
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd7, 32'sd0);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'd0, 32'sd0);
    // reserved code does nothing
    queue_cmd(OP_RESERVED, 16'hFFFF, spa_pkg::COEF_MIN);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'd0, 32'sd0);
    // lists out of order walk as stored
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd1, 32'sd5);
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd9, 32'sd6);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'd9, 32'sd7);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'd1, 32'sd8);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'd0, 32'sd0);
    // repeated exponent inside one list is not merged
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd4, 32'sd1);
    queue_cmd(spa_pkg::OP_LOAD_A, 16'd4, 32'sd2);
    queue_cmd(spa_pkg::OP_LOAD_B, 16'd4, 32'sd3);
    queue_cmd(spa_pkg::OP_COMPUTE, 16'd0, 32'sd0);
    queue_random(70);
    wait_drained();

    // Phase: sender mostly idle
    send_idle_pct = 80;
    queue_random(70);
    wait_drained();

    // Phase: receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 80;
    queue_random(70);
    wait_drained();

    // Phase: both sides idle now and then
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    queue_random(50);
    wait_drained();

    // Pressure: receiver holds off while the sender keeps streaming, so the
    // merge stalls and the command queue fills behind it
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(30);
    hold_go = 1'b1;
    @(negedge clk);
    hold_go = 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
